[hdl/uarttr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transmit/receive ring buffer package
// Shared types and constants for the buffered serial front end.
// ----------------------------------------------------------------------------
package uarttr_pkg;

  localparam int unsigned QueueDepthDef = 256;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned LevelMax      = 255;

  typedef enum logic [1:0] {
    KIND_HOST_SEND = 2'd0,
    KIND_HOST_READ = 2'd1,
    KIND_LINE_DONE = 2'd2,
    KIND_LINE_RECV = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SEND_FULL  = 2'd1,
    ST_RECV_EMPTY = 2'd2,
    ST_RECV_DROP  = 2'd3
  } status_e;

  typedef logic [ByteW-1:0] byte_t;

endpackage

[hdl/uarttr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer channel interfaces
// Valid/ready channels for the event input and the result output.
// ----------------------------------------------------------------------------
interface uarttr_in_if
  import uarttr_pkg::*;
();
  logic  valid;
  logic  ready;
  kind_e kind;
  byte_t data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface uarttr_out_if
  import uarttr_pkg::*;
();
  logic    valid;
  logic    ready;
  status_e status;
  byte_t   read_data;
  logic    line_send;
  byte_t   line_byte;
  logic    busy_now;
  byte_t   send_level;
  byte_t   recv_level;

  modport source (
    output valid, output status, output read_data, output line_send,
    output line_byte, output busy_now, output send_level, output recv_level,
    input ready
  );
  modport sink (
    input valid, input status, input read_data, input line_send,
    input line_byte, input busy_now, input send_level, input recv_level,
    output ready
  );
endinterface

[hdl/uarttr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module uarttr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/uart_tx_rx_ring_buffers_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transmit/receive ring buffers
// Send and receive byte queues with transmitter hand-off and host access.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  in_i     in   kind, data_byte
//  out_o    out  status, read_data, line_send, line_byte, busy_now,
//                send_level, recv_level
//
// One item per cycle while the output is not stalled; each result appears in
// the cycle after its item is taken, when the byte read from the send or receive RAM is available.
// The result register frees as its beat leaves, so input ready follows
// output ready whenever a result is pending.
// Reset clears the pointers, the busy flag and the output valid flag; the RAMs need no clearing.
module uart_tx_rx_ring_buffers_core
  import uarttr_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  uarttr_in_if.sink    in_i,
  uarttr_out_if.source out_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned LvlW = (PtrW + 1 > 9) ? PtrW + 1 : 9;

  typedef logic [PtrW-1:0] ptr_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  function automatic byte_t ptr_level(input ptr_t h, input ptr_t t);
    logic [LvlW-1:0] lvl;
    if (t >= h) begin
      lvl = LvlW'(t) - LvlW'(h);
    end else begin
      lvl = LvlW'(t) + LvlW'(QueueDepth) - LvlW'(h);
    end
    return (lvl > LvlW'(LevelMax)) ? byte_t'(LevelMax) : lvl[ByteW-1:0];
  endfunction

  ptr_t sh_q, sh_d, st_q, st_d, rh_q, rh_d, rt_q, rt_d;
  logic busy_q, busy_d;
  logic vld_q;

  status_e status_q, status_d;
  logic    ls_q, ls_d;
  logic    lb_ram_q, lb_ram_d;
  logic    rd_ram_q, rd_ram_d;
  byte_t   byte_q;
  byte_t   slvl_q, rlvl_q;

  logic  accept;
  logic  send_we, send_re, recv_we, recv_re;
  byte_t send_rdata, recv_rdata;

  assign in_i.ready = !vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    sh_d     = sh_q;
    st_d     = st_q;
    rh_d     = rh_q;
    rt_d     = rt_q;
    busy_d   = busy_q;
    status_d = ST_OK;
    ls_d     = 1'b0;
    lb_ram_d = 1'b0;
    rd_ram_d = 1'b0;
    send_we  = 1'b0;
    send_re  = 1'b0;
    recv_we  = 1'b0;
    recv_re  = 1'b0;
    if (accept) begin
      unique case (in_i.kind)
        KIND_HOST_SEND: begin
          if (ptr_next(st_q) == sh_q) begin
            status_d = ST_SEND_FULL;
          end else begin
            send_we = 1'b1;
            st_d    = ptr_next(st_q);
            if (!busy_q) begin
              // An idle transmitter implies an empty queue, so the new byte
              // goes straight to the line.
              ls_d   = 1'b1;
              sh_d   = ptr_next(sh_q);
              busy_d = 1'b1;
            end
          end
        end
        KIND_HOST_READ: begin
          if (rh_q == rt_q) begin
            status_d = ST_RECV_EMPTY;
          end else begin
            recv_re  = 1'b1;
            rd_ram_d = 1'b1;
            rh_d     = ptr_next(rh_q);
          end
        end
        KIND_LINE_DONE: begin
          if (sh_q != st_q) begin
            send_re  = 1'b1;
            ls_d     = 1'b1;
            lb_ram_d = 1'b1;
            sh_d     = ptr_next(sh_q);
            busy_d   = 1'b1;
          end else begin
            busy_d = 1'b0;
          end
        end
        KIND_LINE_RECV: begin
          if (ptr_next(rt_q) == rh_q) begin
            status_d = ST_RECV_DROP;
          end else begin
            recv_we = 1'b1;
            rt_d    = ptr_next(rt_q);
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q   <= '0;
      st_q   <= '0;
      rh_q   <= '0;
      rt_q   <= '0;
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      sh_q   <= sh_d;
      st_q   <= st_d;
      rh_q   <= rh_d;
      rt_q   <= rt_d;
      busy_q <= busy_d;
      if (in_i.ready) begin
        vld_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      ls_q     <= ls_d;
      lb_ram_q <= lb_ram_d;
      rd_ram_q <= rd_ram_d;
      byte_q   <= in_i.data_byte;
      slvl_q   <= ptr_level(sh_d, st_d);
      rlvl_q   <= ptr_level(rh_d, rt_d);
    end
  end

  uarttr_ram #(
    .Width (ByteW),
    .Depth (QueueDepth)
  ) u_send_ram (
    .clk_i   (clk_i),
    .we_i    (send_we),
    .waddr_i (st_q),
    .wdata_i (in_i.data_byte),
    .re_i    (send_re),
    .raddr_i (sh_q),
    .rdata_o (send_rdata)
  );

  uarttr_ram #(
    .Width (ByteW),
    .Depth (QueueDepth)
  ) u_recv_ram (
    .clk_i   (clk_i),
    .we_i    (recv_we),
    .waddr_i (rt_q),
    .wdata_i (in_i.data_byte),
    .re_i    (recv_re),
    .raddr_i (rh_q),
    .rdata_o (recv_rdata)
  );

  assign out_o.valid      = vld_q;
  assign out_o.status     = status_q;
  assign out_o.read_data  = rd_ram_q ? recv_rdata : '0;
  assign out_o.line_send  = ls_q;
  assign out_o.line_byte  = !ls_q ? '0 : (lb_ram_q ? send_rdata : byte_q);
  assign out_o.busy_now   = busy_q;
  assign out_o.send_level = slvl_q;
  assign out_o.recv_level = rlvl_q;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the UART transmit/receive ring buffers
// Drives host sends, host reads, line-done events and received bytes with
// random gaps and stalls. A scoreboard tracks both byte queues and the
// transmitter busy flag, and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  import uarttr_pkg::*;

  localparam int unsigned RingDepth  = QueueDepthDef;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    status_e status;
    byte_t   read_data;
    logic    line_send;
    byte_t   line_byte;
    logic    busy_now;
    byte_t   send_level;
    byte_t   recv_level;
  } beat_t;

  typedef enum int unsigned {
    MODE_MIX,
    MODE_SEND_FILL,
    MODE_SEND_DRAIN,
    MODE_RECV_FILL,
    MODE_RECV_DRAIN
  } run_mode_e;

  class ring_tracker;
    byte_t       send_ring [RingDepth];
    byte_t       recv_ring [RingDepth];
    int unsigned send_head;
    int unsigned send_tail;
    int unsigned recv_head;
    int unsigned recv_tail;
    bit          line_busy;
    beat_t       due_beats [$];
    int unsigned mismatches;

    function int unsigned ring_next(int unsigned p);
      return (p + 1 >= RingDepth) ? 0 : p + 1;
    endfunction

    function byte_t ring_level(int unsigned head, int unsigned tail);
      int unsigned n;
      n = (tail + RingDepth - head) % RingDepth;
      return (n > LevelMax) ? byte_t'(LevelMax) : byte_t'(n);
    endfunction

    function void hand_to_line(ref beat_t b);
      b.line_byte = send_ring[send_head];
      b.line_send = 1'b1;
      send_head   = ring_next(send_head);
      line_busy   = 1'b1;
    endfunction

    function void note_event(kind_e kind, byte_t data);
      beat_t b;
      b.status    = ST_OK;
      b.read_data = '0;
      b.line_send = 1'b0;
      b.line_byte = '0;
      case (kind)
        KIND_HOST_SEND: begin
          if (ring_next(send_tail) == send_head) begin
            b.status = ST_SEND_FULL;
          end else begin
            send_ring[send_tail] = data;
            send_tail = ring_next(send_tail);
            if (!line_busy) hand_to_line(b);
          end
        end
        KIND_HOST_READ: begin
          if (recv_head == recv_tail) begin
            b.status = ST_RECV_EMPTY;
          end else begin
            b.read_data = recv_ring[recv_head];
            recv_head = ring_next(recv_head);
          end
        end
        KIND_LINE_DONE: begin
          if (send_head != send_tail) hand_to_line(b);
          else line_busy = 1'b0;
        end
        default: begin
          if (ring_next(recv_tail) == recv_head) begin
            b.status = ST_RECV_DROP;
          end else begin
            recv_ring[recv_tail] = data;
            recv_tail = ring_next(recv_tail);
          end
        end
      endcase
      b.busy_now   = line_busy;
      b.send_level = ring_level(send_head, send_tail);
      b.recv_level = ring_level(recv_head, recv_tail);
      due_beats.push_back(b);
    endfunction

    task report(string what, int got, int want);
      mismatches++;
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_beat(beat_t got);
      beat_t want;
      if (due_beats.size() == 0) begin
        report("unexpected beat", 1, 0);
        return;
      end
      want = due_beats.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.read_data !== want.read_data)
        report("read_data", got.read_data, want.read_data);
      if (got.line_send !== want.line_send)
        report("line_send", got.line_send, want.line_send);
      if (got.line_byte !== want.line_byte)
        report("line_byte", got.line_byte, want.line_byte);
      if (got.busy_now !== want.busy_now)
        report("busy_now", got.busy_now, want.busy_now);
      if (got.send_level !== want.send_level)
        report("send_level", got.send_level, want.send_level);
      if (got.recv_level !== want.recv_level)
        report("recv_level", got.recv_level, want.recv_level);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  bit          calm;
  int unsigned cycle_count;
  ring_tracker tracker = new();

  uarttr_in_if  in_if ();
  uarttr_out_if out_if ();

  uart_tx_rx_ring_buffers_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    beat_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.status     = out_if.status;
      got.read_data  = out_if.read_data;
      got.line_send  = out_if.line_send;
      got.line_byte  = out_if.line_byte;
      got.busy_now   = out_if.busy_now;
      got.send_level = out_if.send_level;
      got.recv_level = out_if.recv_level;
      tracker.check_beat(got);
    end
  end

  // The result side may stall before each beat it takes.
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task push_item(kind_e kind, byte_t data);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.data_byte <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tracker.note_event(kind, data);
  endtask

  function automatic kind_e pick_kind(run_mode_e mode);
    kind_e any;
    any = kind_e'($urandom_range(0, 3));
    if (mode == MODE_MIX || $urandom_range(0, 99) < 6) return any;
    case (mode)
      MODE_SEND_FILL:  return KIND_HOST_SEND;
      MODE_SEND_DRAIN: return KIND_LINE_DONE;
      MODE_RECV_FILL:  return KIND_LINE_RECV;
      MODE_RECV_DRAIN: return KIND_HOST_READ;
      default:         return any;
    endcase
  endfunction

  task run_segment(run_mode_e mode, int unsigned count);
    calm = ($urandom_range(0, 3) == 0);
    repeat (count) push_item(pick_kind(mode), byte_t'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned done_items;
    int unsigned seg_len;
    rst_ni          = 1'b0;
    calm            = 1'b0;
    in_if.valid     = 1'b0;
    in_if.kind      = KIND_HOST_SEND;
    in_if.data_byte = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty queues, idle line, byte extremes, ignored data on reads and
    // line-done events.
    push_item(KIND_HOST_READ, 8'hFF);
    push_item(KIND_LINE_DONE, 8'hFF);
    push_item(KIND_HOST_SEND, 8'h00);
    push_item(KIND_HOST_SEND, 8'hFF);
    push_item(KIND_HOST_SEND, 8'h5A);
    push_item(KIND_LINE_DONE, 8'h00);
    push_item(KIND_LINE_DONE, 8'hA5);
    push_item(KIND_LINE_DONE, 8'h00);
    push_item(KIND_LINE_DONE, 8'h00);
    push_item(KIND_LINE_RECV, 8'h00);
    push_item(KIND_LINE_RECV, 8'hFF);
    push_item(KIND_LINE_RECV, 8'hA5);
    push_item(KIND_HOST_READ, 8'h00);
    push_item(KIND_HOST_READ, 8'hFF);
    push_item(KIND_HOST_READ, 8'h00);
    push_item(KIND_HOST_READ, 8'h00);
    push_item(KIND_HOST_SEND, 8'h80);
    push_item(KIND_LINE_DONE, 8'h7F);
    push_item(KIND_LINE_DONE, 8'h01);

    // Fill both queues past full, then wander through random modes so the
    // pointers wrap.
    run_segment(MODE_SEND_FILL, 300);
    run_segment(MODE_RECV_FILL, 300);
    done_items = 600;
    while (done_items < 1100) begin
      seg_len = $urandom_range(20, 150);
      run_segment(run_mode_e'($urandom_range(0, 4)), seg_len);
      done_items += seg_len;
    end
    in_if.valid <= 1'b0;

    while (tracker.due_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/uarttr_pkg.sv
hdl/uarttr_if.sv
hdl/uarttr_ram.sv
hdl/uart_tx_rx_ring_buffers_core.sv
sim/tb_top.sv
